>>> rtl/frd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frd_pkg: shared definitions for the frame receiver
// Frame phases, link code bytes, payload limit and register indexes.
// ----------------------------------------------------------------------------
package frd_pkg;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_FLAG  = 3'd1,
        PH_ADDR  = 3'd2,
        PH_CTRL  = 3'd3,
        PH_HDR   = 3'd4,
        PH_STOP  = 3'd5
    } phase_t;

    localparam logic [7:0] C_FLAG     = 8'h7E;
    localparam logic [7:0] C_ESC      = 8'h7D;
    localparam logic [7:0] C_ESC_FLAG = 8'h5E;
    localparam logic [7:0] C_ESC_ESC  = 8'h5D;
    localparam logic [7:0] C_SET      = 8'h03;
    localparam logic [7:0] C_RR0      = 8'hAA;
    localparam logic [7:0] C_RR1      = 8'hAB;
    localparam logic [7:0] C_REJ0     = 8'h54;
    localparam logic [7:0] C_REJ1     = 8'h55;
    localparam logic [7:0] C_I0       = 8'h00;
    localparam logic [7:0] C_I1       = 8'h80;

    localparam int MAX_PAYLOAD = 1024;
    localparam int COUNT_W     = $clog2(MAX_PAYLOAD + 1);
    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_PAYLOAD);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_RECEIVER_SIDE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_ADDRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_CONTROL = 2'd2;

    localparam logic       RST_RECEIVER_SIDE    = 1'b1;
    localparam logic [7:0] RST_EXPECTED_ADDRESS = 8'h03;
    localparam logic [7:0] RST_EXPECTED_CONTROL = 8'h00;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

endpackage
`default_nettype wire

>>> rtl/frd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frd_in_if: input word channel of the frame receiver
// Carries one line byte or a restart request per word.
// ----------------------------------------------------------------------------
interface frd_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface
`default_nettype wire

>>> rtl/frd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frd_out_if: result word channel of the frame receiver
// Carries the phase, the destuffed data byte and the per-step status bits.
// ----------------------------------------------------------------------------
interface frd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] phase;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       frame_done;
    logic       reject;
    logic       set_seen;
    logic       duplicate;
    logic       header_error;
    logic       payload_error;
    logic       overflow;

    modport source (
        output valid, output phase, output data_valid, output data_byte,
        output frame_done, output reject, output set_seen, output duplicate,
        output header_error, output payload_error, output overflow,
        input ready
    );
    modport sink (
        input valid, input phase, input data_valid, input data_byte,
        input frame_done, input reject, input set_seen, input duplicate,
        input header_error, input payload_error, input overflow,
        output ready
    );
endinterface
`default_nettype wire

>>> rtl/frame_receiver_destuff_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_receiver_destuff_check: byte-wise frame receiver with destuffing
// Tracks flag, address, control and header check, destuffs the payload,
// checks its trailing XOR byte and reports one result word per input word.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle and returns exactly one result
// word for it in the next cycle. All decisions for a word are made by a
// single level of logic from the stored frame state, and the result lands in
// an output register; a new word is accepted whenever that register is empty
// or is being taken in the same cycle, so a stalled consumer costs throughput
// only while the register is full. A restart word (opcode 1) drops the
// current frame and returns to the start phase with all frame flags cleared;
// the three configuration registers keep their values and should be written
// only while no result word is outstanding. Payload bytes come out destuffed
// and delayed by one stored byte, so the final check byte is never shown.
// ----------------------------------------------------------------------------
module frame_receiver_destuff_check (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [frd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data,
    frd_in_if.sink                             din,
    frd_out_if.source                          dout
);
    import frd_pkg::*;

    // Configuration registers.
    logic       receiver_side_reg;
    logic [7:0] exp_addr_reg;
    logic [7:0] exp_ctrl_reg;

    // Frame state and its next values.
    phase_t             phase_reg, phase_next;
    logic               reject_reg, reject_next;
    logic               set_reg, set_next;
    logic               dup_reg, dup_next;
    logic               esc_reg, esc_next;
    logic [7:0]         hxor_reg, hxor_next;
    logic [7:0]         pxor_reg, pxor_next;
    logic [7:0]         held_reg, held_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    // Result word register.
    logic       out_valid_reg;
    phase_t     out_phase_reg;
    logic       out_dv_reg, out_dv_next;
    logic [7:0] out_dbyte_reg, out_dbyte_next;
    logic       out_done_reg, out_done_next;
    logic       out_herr_reg, out_herr_next;
    logic       out_perr_reg, out_perr_next;
    logic       out_ovf_reg, out_ovf_next;
    logic       out_rej_reg, out_set_reg, out_dup_reg;

    logic       accept;
    logic       restart;
    logic [7:0] b;

    // Control byte classification in the address phase.
    logic ctrl_match, ctrl_rej, ctrl_set, ctrl_dup, ctrl_ok;
    // Payload byte classification in the header-ok phase.
    logic       data_mode;
    logic       room;
    logic       esc_store;
    logic       esc_bad;
    logic [7:0] esc_value;
    logic       pay_empty_or_bad;

    assign din.ready = !out_valid_reg || dout.ready;
    assign accept    = din.valid && din.ready;
    assign restart   = (din.opcode == OP_RESTART);
    assign b         = din.rx_byte;

    // The opposite REJ is only taken by a sender waiting on an RR; SET and the
    // opposite I-frame number only by a receiver. An exact match wins first.
    always_comb
    begin
        ctrl_match = (b == exp_ctrl_reg);
        ctrl_rej   = !ctrl_match && !receiver_side_reg &&
                     (((exp_ctrl_reg == C_RR0) && (b == C_REJ1)) ||
                      ((exp_ctrl_reg == C_RR1) && (b == C_REJ0)));
        ctrl_set   = !ctrl_match && !ctrl_rej && receiver_side_reg && (b == C_SET);
        ctrl_dup   = !ctrl_match && !ctrl_rej && !ctrl_set && receiver_side_reg &&
                     (((exp_ctrl_reg == C_I0) && (b == C_I1)) ||
                      ((exp_ctrl_reg == C_I1) && (b == C_I0)));
        ctrl_ok    = ctrl_match || ctrl_rej || ctrl_set || ctrl_dup;
    end

    // Destuffing: an escape byte is swallowed and modifies the next byte; any
    // byte after an escape other than the two escaped codes is dropped.
    always_comb
    begin
        data_mode        = receiver_side_reg && !set_reg;
        room             = (count_reg < MAX_COUNT);
        esc_store        = 1'b1;
        esc_bad          = 1'b0;
        esc_value        = b;
        pay_empty_or_bad = (count_reg == '0) || (pxor_reg != 8'h00);
        if (esc_reg)
        begin
            if (b == C_ESC_FLAG)
            begin
                esc_value = C_FLAG;
            end
            else if (b == C_ESC_ESC)
            begin
                esc_value = C_ESC;
            end
            else
            begin
                esc_bad   = 1'b1;
                esc_store = 1'b0;
            end
        end
        else if (b == C_ESC)
        begin
            esc_store = 1'b0;
        end
    end

    // Next frame state.
    always_comb
    begin
        phase_next  = phase_reg;
        reject_next = reject_reg;
        set_next    = set_reg;
        dup_next    = dup_reg;
        esc_next    = esc_reg;
        hxor_next   = hxor_reg;
        pxor_next   = pxor_reg;
        held_next   = held_reg;
        count_next  = count_reg;
        if (restart)
        begin
            phase_next  = PH_START;
            reject_next = 1'b0;
            set_next    = 1'b0;
            dup_next    = 1'b0;
            esc_next    = 1'b0;
            hxor_next   = 8'h00;
            pxor_next   = 8'h00;
            held_next   = 8'h00;
            count_next  = '0;
        end
        else
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (b == C_FLAG)
                    begin
                        phase_next = PH_FLAG;
                    end
                end
                PH_FLAG:
                begin
                    reject_next = 1'b0;
                    set_next    = 1'b0;
                    dup_next    = 1'b0;
                    pxor_next   = 8'h00;
                    if (b == exp_addr_reg)
                    begin
                        phase_next = PH_ADDR;
                        hxor_next  = b;
                    end
                    else if (b != C_FLAG)
                    begin
                        phase_next = PH_START;
                    end
                end
                PH_ADDR:
                begin
                    if (ctrl_ok)
                    begin
                        phase_next = PH_CTRL;
                        hxor_next  = hxor_reg ^ b;
                        if (ctrl_rej)
                        begin
                            reject_next = 1'b1;
                        end
                        if (ctrl_set)
                        begin
                            set_next = 1'b1;
                        end
                        if (ctrl_dup)
                        begin
                            dup_next = 1'b1;
                        end
                    end
                    else if (b == C_FLAG)
                    begin
                        phase_next = PH_FLAG;
                    end
                    else
                    begin
                        phase_next = PH_START;
                    end
                end
                PH_CTRL:
                begin
                    if (b == hxor_reg)
                    begin
                        count_next = '0;
                        esc_next   = 1'b0;
                        phase_next = PH_HDR;
                    end
                    else if (b == C_FLAG)
                    begin
                        phase_next = PH_FLAG;
                    end
                    else
                    begin
                        phase_next = PH_START;
                    end
                end
                PH_HDR:
                begin
                    if (b == C_FLAG)
                    begin
                        phase_next = PH_STOP;
                        if (data_mode && pay_empty_or_bad)
                        begin
                            reject_next = 1'b1;
                        end
                    end
                    else if (!data_mode || !room)
                    begin
                        phase_next = PH_START;
                    end
                    else
                    begin
                        esc_next = !esc_reg && (b == C_ESC);
                        if (esc_bad)
                        begin
                            reject_next = 1'b1;
                        end
                        if (esc_store)
                        begin
                            held_next  = esc_value;
                            pxor_next  = pxor_reg ^ esc_value;
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    // The stop phase ignores bytes until a restart.
                end
            endcase
        end
    end

    // Per-word pulse outputs.
    always_comb
    begin
        out_dv_next    = 1'b0;
        out_dbyte_next = 8'h00;
        out_done_next  = 1'b0;
        out_herr_next  = 1'b0;
        out_perr_next  = 1'b0;
        out_ovf_next   = 1'b0;
        if (!restart)
        begin
            case (phase_reg)
                PH_CTRL:
                begin
                    out_herr_next = (b != hxor_reg) && (b != C_FLAG);
                end
                PH_HDR:
                begin
                    if (b == C_FLAG)
                    begin
                        out_done_next = 1'b1;
                        out_perr_next = data_mode && pay_empty_or_bad;
                    end
                    else if (data_mode && !room)
                    begin
                        out_ovf_next = 1'b1;
                    end
                    else if (data_mode && esc_store && (count_reg != '0))
                    begin
                        // The byte held since the last store is now known not to
                        // be the check byte, so it is released.
                        out_dv_next    = 1'b1;
                        out_dbyte_next = held_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiver_side_reg <= RST_RECEIVER_SIDE;
            exp_addr_reg      <= RST_EXPECTED_ADDRESS;
            exp_ctrl_reg      <= RST_EXPECTED_CONTROL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RECEIVER_SIDE:    receiver_side_reg <= cfg_data[0];
                REG_EXPECTED_ADDRESS: exp_addr_reg      <= cfg_data;
                REG_EXPECTED_CONTROL: exp_ctrl_reg      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            reject_reg <= 1'b0;
            set_reg    <= 1'b0;
            dup_reg    <= 1'b0;
            esc_reg    <= 1'b0;
            hxor_reg   <= 8'h00;
            pxor_reg   <= 8'h00;
            held_reg   <= 8'h00;
            count_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            reject_reg <= reject_next;
            set_reg    <= set_next;
            dup_reg    <= dup_next;
            esc_reg    <= esc_next;
            hxor_reg   <= hxor_next;
            pxor_reg   <= pxor_next;
            held_reg   <= held_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_phase_reg <= phase_next;
            out_dv_reg    <= out_dv_next;
            out_dbyte_reg <= out_dbyte_next;
            out_done_reg  <= out_done_next;
            out_rej_reg   <= reject_next;
            out_set_reg   <= set_next;
            out_dup_reg   <= dup_next;
            out_herr_reg  <= out_herr_next;
            out_perr_reg  <= out_perr_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

    assign dout.valid         = out_valid_reg;
    assign dout.phase         = out_phase_reg;
    assign dout.data_valid    = out_dv_reg;
    assign dout.data_byte     = out_dbyte_reg;
    assign dout.frame_done    = out_done_reg;
    assign dout.reject        = out_rej_reg;
    assign dout.set_seen      = out_set_reg;
    assign dout.duplicate     = out_dup_reg;
    assign dout.header_error  = out_herr_reg;
    assign dout.payload_error = out_perr_reg;
    assign dout.overflow      = out_ovf_reg;

endmodule
`default_nettype wire

>>> rtl/frd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frd_checker: port-level assertions for the frame receiver
// Checks result word consistency and output register flow control.
// ----------------------------------------------------------------------------
module frd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] phase,
    input wire logic       data_valid,
    input wire logic [7:0] data_byte,
    input wire logic       frame_done,
    input wire logic       reject,
    input wire logic       payload_error,
    input wire logic       overflow
);
    import frd_pkg::*;

    // A stalled result word keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(phase) &&
            $stable(data_valid) && $stable(data_byte))
        else $error("result word changed while stalled");

    // An empty output register never blocks the input.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output register");

    // Payload bytes only come out in the header-ok phase.
    a_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && data_valid |-> phase == PH_HDR && !overflow && !frame_done)
        else $error("data byte outside the payload phase");

    // A payload error closes the frame and marks it rejected.
    a_perr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_error |-> frame_done && reject && phase == PH_STOP)
        else $error("payload error without a rejected closed frame");

    // Overflow always returns to the start phase.
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> phase == PH_START)
        else $error("overflow without return to start");

endmodule

bind frame_receiver_destuff_check frd_checker u_frd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (din.ready),
    .out_valid     (dout.valid),
    .out_ready     (dout.ready),
    .phase         (dout.phase),
    .data_valid    (dout.data_valid),
    .data_byte     (dout.data_byte),
    .frame_done    (dout.frame_done),
    .reject        (dout.reject),
    .payload_error (dout.payload_error),
    .overflow      (dout.overflow)
);
`default_nettype wire
